@@ src/oes_pkg.sv @@
// Shared constants, codes and handshake types for the orbit Euler stepper.
package oes_pkg;

    localparam int FRAC_BITS_DEF = 32;
    localparam int WORD_BITS_DEF = 48;

    localparam int STEP_W    = 32;
    localparam int STEP_FRAC = 32;
    localparam int GRAV_W    = 48;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 48;
    localparam int WIDE_W    = 128;
    localparam int HALF_W    = 64;
    localparam int CNT_W     = 7;

    localparam logic [STEP_W-1:0] STEP_RESET = 32'd4294967;
    localparam logic [GRAV_W-1:0] GRAV_RESET = 48'd169558512490;

    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAV_MASS = 8'd1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef enum logic [1:0] {
        ALU_MUL  = 2'd0,
        ALU_DIV  = 2'd1,
        ALU_SQRT = 2'd2
    } alu_op_t;

    // x + y*z for a multiply, x / y for a divide, sqrt(x) for a root.
    typedef struct packed {
        logic              start;
        alu_op_t           op;
        logic [WIDE_W-1:0] x;
        logic [HALF_W-1:0] y;
        logic [HALF_W-1:0] z;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [WIDE_W-1:0] result;
    } alu_rsp_t;

endpackage

@@ src/oes_alu.sv @@
// Bit-serial shared unit: multiply-accumulate, long division and integer square root.
module oes_alu (
    input  logic              aclk,
    input  logic              aresetn,
    input  oes_pkg::alu_req_t req,
    output oes_pkg::alu_rsp_t rsp
);

    localparam int WW = oes_pkg::WIDE_W;
    localparam int HW = oes_pkg::HALF_W;
    localparam int CW = oes_pkg::CNT_W;

    oes_pkg::alu_op_t op_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [WW-1:0]    acc_reg, acc_next;
    logic [WW-1:0]    sh_reg, sh_next;
    logic [HW-1:0]    aux_reg, aux_next;
    logic [CW-1:0]    last_cnt;

    logic [WW-1:0]    mul_sum;
    logic [HW:0]      div_remw, div_diff;
    logic [HW+3:0]    sq_remw, sq_trial, sq_diff;

    always_comb begin
        mul_sum  = acc_reg + (aux_reg[0] ? sh_reg : '0);
        div_remw = {sh_reg[HW-1:0], acc_reg[WW-1]};
        div_diff = div_remw - {1'b0, aux_reg};
        sq_remw  = {sh_reg[HW+1:0], acc_reg[WW-1:WW-2]};
        sq_trial = {2'b00, aux_reg, 2'b01};
        sq_diff  = sq_remw - sq_trial;
    end

    always_comb begin
        acc_next = acc_reg;
        sh_next  = sh_reg;
        aux_next = aux_reg;
        last_cnt = CW'(HW - 1);
        if (req.start) begin
            acc_next = req.x;
            unique case (req.op)
                oes_pkg::ALU_MUL: begin
                    sh_next  = WW'(req.z);
                    aux_next = req.y;
                end
                oes_pkg::ALU_DIV: begin
                    sh_next  = '0;
                    aux_next = req.y;
                end
                default: begin
                    sh_next  = '0;
                    aux_next = '0;
                end
            endcase
        end else if (busy_reg) begin
            unique case (op_reg)
                oes_pkg::ALU_MUL: begin
                    acc_next = mul_sum;
                    sh_next  = {sh_reg[WW-2:0], 1'b0};
                    aux_next = {1'b0, aux_reg[HW-1:1]};
                end
                oes_pkg::ALU_DIV: begin
                    last_cnt = CW'(WW - 1);
                    if (div_remw >= {1'b0, aux_reg}) begin
                        acc_next = {acc_reg[WW-2:0], 1'b1};
                        sh_next  = WW'(div_diff);
                    end else begin
                        acc_next = {acc_reg[WW-2:0], 1'b0};
                        sh_next  = WW'(div_remw);
                    end
                end
                default: begin
                    acc_next = {acc_reg[WW-3:0], 2'b00};
                    if (sq_remw >= sq_trial) begin
                        sh_next  = WW'(sq_diff);
                        aux_next = {aux_reg[HW-2:0], 1'b1};
                    end else begin
                        sh_next  = WW'(sq_remw);
                        aux_next = {aux_reg[HW-2:0], 1'b0};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        aux_reg <= aux_next;
        if (req.start) begin
            op_reg <= req.op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == last_cnt) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = (op_reg == oes_pkg::ALU_SQRT) ? WW'(aux_reg) : acc_reg;

    assert property (@(posedge aclk) disable iff (!aresetn) req.start |=> busy_reg)
        else $error("unit did not start on request");
    assert property (@(posedge aclk) disable iff (!aresetn) done_reg |-> !busy_reg)
        else $error("unit done while still busy");
    assert property (@(posedge aclk) disable iff (!aresetn) req.start |-> !busy_reg)
        else $error("request issued while unit busy");

endmodule

@@ src/orbit_euler_step.sv @@
// Top level: symplectic Euler orbit stepper with state, sequencer and result register.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-------------------------------------------
//  cfg       | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//  s_ (in)   | s_valid / s_ready     | command, load position/velocity, start time
//  m_ (out)  | m_valid / m_ready     | time, position, velocity, radius, singular
//
// A load request gives no result. For a step request, every multiply, divide and square
// root runs bit-serially through the one shared unit (eleven multiplies and roots, nine
// divides). A step whose radius is zero skips the rest after the root.
// s_ready is high only while the sequencer is idle; a finished result waits in the
// output register and a later step holds in its last state until that is taken.
// Reset is synchronous: state, clock, position and velocity clear and registers take defaults.
module orbit_euler_step #(
    parameter int FRAC_BITS = oes_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = oes_pkg::WORD_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [oes_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [oes_pkg::CFG_DAT_W-1:0]        cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_command,
    input  logic signed [WORD_BITS-1:0]          s_load_x,
    input  logic signed [WORD_BITS-1:0]          s_load_y,
    input  logic signed [WORD_BITS-1:0]          s_load_z,
    input  logic signed [WORD_BITS-1:0]          s_load_vx,
    input  logic signed [WORD_BITS-1:0]          s_load_vy,
    input  logic signed [WORD_BITS-1:0]          s_load_vz,
    input  logic signed [WORD_BITS-1:0]          s_start_time,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [WORD_BITS-1:0]          m_sim_time,
    output logic signed [WORD_BITS-1:0]          m_pos_x,
    output logic signed [WORD_BITS-1:0]          m_pos_y,
    output logic signed [WORD_BITS-1:0]          m_pos_z,
    output logic signed [WORD_BITS-1:0]          m_vel_x,
    output logic signed [WORD_BITS-1:0]          m_vel_y,
    output logic signed [WORD_BITS-1:0]          m_vel_z,
    output logic [WORD_BITS-1:0]                 m_radius,
    output logic                                 m_singular
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int WW = oes_pkg::WIDE_W;
    localparam int HW = oes_pkg::HALF_W;
    localparam int SW = oes_pkg::STEP_W;
    localparam int GW = oes_pkg::GRAV_W;
    localparam int SF = oes_pkg::STEP_FRAC;
    localparam int HX = SW + SF + 8;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_MOVE   = 10'b0000000010,
        ST_SQUARE = 10'b0000000100,
        ST_ROOT   = 10'b0000001000,
        ST_TMUL   = 10'b0000010000,
        ST_AMUL   = 10'b0000100000,
        ST_DIVA   = 10'b0001000000,
        ST_DIVB   = 10'b0010000000,
        ST_DIVD   = 10'b0100000000,
        ST_DONE   = 10'b1000000000
    } state_t;

    function automatic logic [HW-1:0] mag(input logic signed [W-1:0] v);
        logic [W-1:0] a;
        a = v[W-1] ? W'(-v) : W'(v);
        return HW'(a);
    endfunction

    // a + (neg ? -m : m), clamped to the word range.
    function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                    input logic neg,
                                                    input logic [WW-1:0] m);
        logic signed [W+1:0] ext;
        logic signed [W+1:0] mx;
        logic signed [W-1:0] res;
        mx  = $signed({2'b00, m[W-1:0]});
        ext = neg ? ($signed({{2{a[W-1]}}, a}) - mx) : ($signed({{2{a[W-1]}}, a}) + mx);
        if (|m[WW-1:W]) begin
            res = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else if ((ext[W+1:W-1] != '0) && (ext[W+1:W-1] != '1)) begin
            res = ext[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            res = ext[W-1:0];
        end
        return res;
    endfunction

    function automatic logic [WW-1:0] shl_sat(input logic [WW-1:0] v);
        logic [WW-1:0] res;
        if (|v[WW-1:WW-F]) begin
            res = '1;
        end else begin
            res = v << F;
        end
        return res;
    endfunction

    state_t state_reg, state_next;
    logic   launch_reg, launch_next;
    logic [1:0] idx_reg, idx_next;

    logic [SW-1:0] step_reg;
    logic [GW-1:0] grav_reg;

    logic signed [W-1:0] pos_reg [3];
    logic signed [W-1:0] vel_reg [3];
    logic signed [W-1:0] pos_next [3];
    logic signed [W-1:0] vel_next [3];
    logic signed [W-1:0] clock_reg, clock_next;

    logic [WW-1:0] sum_reg, sum_next;
    logic [WW-1:0] q_reg, q_next;
    logic [W-1:0]  r_reg, r_next;
    logic [GW-1:0] t_reg, t_next;
    logic          sing_reg, sing_next;

    logic          out_load;
    logic          m_valid_reg;
    logic [HX-1:0] hstep;

    oes_pkg::alu_req_t alu_req;
    oes_pkg::alu_rsp_t alu_rsp;

    oes_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .rsp     (alu_rsp)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign hstep     = {8'b0, step_reg, {SF{1'b0}}} >> (2 * SF - F);
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        alu_req.start = launch_reg;
        alu_req.op    = oes_pkg::ALU_MUL;
        alu_req.x     = '0;
        alu_req.y     = '0;
        alu_req.z     = '0;
        unique case (state_reg)
            ST_MOVE: begin
                alu_req.y = mag(vel_reg[idx_reg]);
                alu_req.z = HW'(step_reg);
            end
            ST_SQUARE: begin
                alu_req.x = sum_reg;
                alu_req.y = mag(pos_reg[idx_reg]);
                alu_req.z = mag(pos_reg[idx_reg]);
            end
            ST_ROOT: begin
                alu_req.op = oes_pkg::ALU_SQRT;
                alu_req.x  = sum_reg;
            end
            ST_TMUL: begin
                alu_req.y = HW'(step_reg);
                alu_req.z = HW'(grav_reg);
            end
            ST_AMUL: begin
                alu_req.y = mag(pos_reg[idx_reg]);
                alu_req.z = HW'(t_reg);
            end
            ST_DIVA: begin
                alu_req.op = oes_pkg::ALU_DIV;
                alu_req.x  = q_reg;
                alu_req.y  = HW'(r_reg);
            end
            ST_DIVB, ST_DIVD: begin
                alu_req.op = oes_pkg::ALU_DIV;
                alu_req.x  = shl_sat(q_reg);
                alu_req.y  = HW'(r_reg);
            end
            default: begin
                alu_req.op = oes_pkg::ALU_MUL;
            end
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        launch_next = 1'b0;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        vel_next    = vel_reg;
        clock_next  = clock_reg;
        sum_next    = sum_reg;
        q_next      = q_reg;
        r_next      = r_reg;
        t_next      = t_reg;
        sing_next   = sing_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_command == oes_pkg::CMD_LOAD) begin
                        pos_next[0] = s_load_x;
                        pos_next[1] = s_load_y;
                        pos_next[2] = s_load_z;
                        vel_next[0] = s_load_vx;
                        vel_next[1] = s_load_vy;
                        vel_next[2] = s_load_vz;
                        clock_next  = s_start_time;
                    end else begin
                        idx_next    = '0;
                        sum_next    = '0;
                        sing_next   = 1'b0;
                        launch_next = 1'b1;
                        state_next  = ST_MOVE;
                    end
                end
            end
            ST_MOVE: begin
                if (alu_rsp.done) begin
                    pos_next[idx_reg] = sat_add(pos_reg[idx_reg], vel_reg[idx_reg][W-1],
                                                alu_rsp.result >> SF);
                    launch_next = 1'b1;
                    if (idx_reg == 2'd2) begin
                        idx_next   = '0;
                        state_next = ST_SQUARE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_SQUARE: begin
                if (alu_rsp.done) begin
                    sum_next    = alu_rsp.result;
                    launch_next = 1'b1;
                    if (idx_reg == 2'd2) begin
                        idx_next   = '0;
                        state_next = ST_ROOT;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_ROOT: begin
                if (alu_rsp.done) begin
                    r_next = alu_rsp.result[W-1:0];
                    if (alu_rsp.result == '0) begin
                        sing_next  = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        launch_next = 1'b1;
                        state_next  = ST_TMUL;
                    end
                end
            end
            ST_TMUL: begin
                if (alu_rsp.done) begin
                    t_next      = alu_rsp.result[SF+GW-1:SF];
                    launch_next = 1'b1;
                    state_next  = ST_AMUL;
                end
            end
            ST_AMUL: begin
                if (alu_rsp.done) begin
                    q_next      = alu_rsp.result;
                    launch_next = 1'b1;
                    state_next  = ST_DIVA;
                end
            end
            ST_DIVA: begin
                if (alu_rsp.done) begin
                    q_next      = alu_rsp.result;
                    launch_next = 1'b1;
                    state_next  = ST_DIVB;
                end
            end
            ST_DIVB: begin
                if (alu_rsp.done) begin
                    q_next      = alu_rsp.result;
                    launch_next = 1'b1;
                    state_next  = ST_DIVD;
                end
            end
            ST_DIVD: begin
                if (alu_rsp.done) begin
                    // The pull points back to the star, against the sign of the coordinate.
                    vel_next[idx_reg] = sat_add(vel_reg[idx_reg],
                                                !pos_reg[idx_reg][W-1] && (pos_reg[idx_reg] != '0),
                                                alu_rsp.result);
                    if (idx_reg == 2'd2) begin
                        idx_next   = '0;
                        state_next = ST_DONE;
                    end else begin
                        idx_next    = idx_reg + 1'b1;
                        launch_next = 1'b1;
                        state_next  = ST_AMUL;
                    end
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    clock_next = sat_add(clock_reg, 1'b0, WW'(hstep));
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            launch_reg  <= 1'b0;
            idx_reg     <= '0;
            step_reg    <= oes_pkg::STEP_RESET;
            grav_reg    <= oes_pkg::GRAV_RESET;
            pos_reg     <= '{default: '0};
            vel_reg     <= '{default: '0};
            clock_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            idx_reg    <= idx_next;
            pos_reg    <= pos_next;
            vel_reg    <= vel_next;
            clock_reg  <= clock_next;
            if (cfg_valid) begin
                if (cfg_index == oes_pkg::REG_TIME_STEP) begin
                    step_reg <= cfg_data[SW-1:0];
                end else if (cfg_index == oes_pkg::REG_GRAV_MASS) begin
                    grav_reg <= cfg_data[GW-1:0];
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg  <= sum_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        t_reg    <= t_next;
        sing_reg <= sing_next;
        if (out_load) begin
            m_sim_time <= clock_reg;
            m_pos_x    <= pos_reg[0];
            m_pos_y    <= pos_reg[1];
            m_pos_z    <= pos_reg[2];
            m_vel_x    <= vel_reg[0];
            m_vel_y    <= vel_reg[1];
            m_vel_z    <= vel_reg[2];
            m_radius   <= r_reg;
            m_singular <= sing_reg;
        end
    end

    assign m_valid = m_valid_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !alu_rsp.done)
        else $error("arithmetic unit finished with no step in progress");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_singular |-> (m_radius == '0))
        else $error("singular result with nonzero radius");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_command == oes_pkg::CMD_STEP) |=> !s_ready)
        else $error("step request did not start the sequencer");
    assert property (@(posedge aclk) disable iff (!aresetn)
        launch_reg |=> !alu_rsp.done)
        else $error("arithmetic unit answered in one cycle");

endmodule

@@ verif/oes_checker.sv @@
// Checker for the orbit stepper: watches all channels, predicts each step result and compares.
module oes_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [oes_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [oes_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_command,
    input  logic signed [47:0]            s_load_x,
    input  logic signed [47:0]            s_load_y,
    input  logic signed [47:0]            s_load_z,
    input  logic signed [47:0]            s_load_vx,
    input  logic signed [47:0]            s_load_vy,
    input  logic signed [47:0]            s_load_vz,
    input  logic signed [47:0]            s_start_time,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic signed [47:0]            m_sim_time,
    input  logic signed [47:0]            m_pos_x,
    input  logic signed [47:0]            m_pos_y,
    input  logic signed [47:0]            m_pos_z,
    input  logic signed [47:0]            m_vel_x,
    input  logic signed [47:0]            m_vel_y,
    input  logic signed [47:0]            m_vel_z,
    input  logic [47:0]                   m_radius,
    input  logic                          m_singular,
    output int                            fail_count,
    output int                            pending,
    output int                            steps_seen,
    output int                            singular_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [47:0] word_t;

    typedef struct {
        word_t       sim_time;
        word_t       pos[3];
        word_t       vel[3];
        logic [47:0] radius;
        logic        singular;
    } orbit_state_t;

    orbit_state_t                awaited[$];
    logic [oes_pkg::STEP_W-1:0]  h_reg;
    logic [oes_pkg::GRAV_W-1:0]  gm_reg;
    word_t                       body_pos[3];
    word_t                       body_vel[3];
    word_t                       body_clock;

    assign pending = awaited.size();

    function automatic word_t sat_add(word_t a, bit neg, logic [63:0] m);
        logic signed [66:0] s;
        s = neg ? ($signed({{19{a[47]}}, a}) - $signed({3'b0, m}))
                : ($signed({{19{a[47]}}, a}) + $signed({3'b0, m}));
        if (s > 67'sd140737488355327) return 48'sh7FFF_FFFF_FFFF;
        if (s < -67'sd140737488355328) return 48'sh8000_0000_0000;
        return s[47:0];
    endfunction

    function automatic logic [63:0] mag(word_t a);
        logic [63:0] ext;
        ext = {{16{a[47]}}, a};
        return a[47] ? -ext : ext;
    endfunction

    function automatic logic [63:0] root_floor(logic [127:0] s);
        logic [63:0]  res;
        logic [63:0]  c;
        logic [127:0] sq;
        res = '0;
        for (int b = 63; b >= 0; b--) begin
            c = res | (64'd1 << b);
            sq = {64'b0, c} * {64'b0, c};
            if (sq <= s) res = c;
        end
        return res;
    endfunction

    function automatic logic [127:0] shl_clamp(logic [127:0] x);
        return (x[127:96] != 0) ? '1 : (x << 32);
    endfunction

    // Advances the predicted body by one step and gives the result it should report.
    function automatic orbit_state_t advance_body();
        orbit_state_t e;
        logic [127:0] prod, sum, a, b, d, rw;
        logic [63:0]  r, t, dm;
        e.sim_time = body_clock;
        for (int i = 0; i < 3; i++) begin
            prod = {64'b0, mag(body_vel[i])} * {96'b0, h_reg};
            body_pos[i] = sat_add(body_pos[i], body_vel[i] < 0, prod[95:32]);
        end
        sum = '0;
        for (int i = 0; i < 3; i++)
            sum = sum + {64'b0, mag(body_pos[i])} * {64'b0, mag(body_pos[i])};
        r = root_floor(sum);
        e.singular = (r == 0);
        if (r != 0) begin
            prod = {96'b0, h_reg} * {80'b0, gm_reg};
            t = prod[95:32];
            rw = {64'b0, r};
            for (int i = 0; i < 3; i++) begin
                a = ({64'b0, mag(body_pos[i])} * {64'b0, t}) / rw;
                b = shl_clamp(a) / rw;
                d = shl_clamp(b) / rw;
                dm = (d[127:64] != 0) ? '1 : d[63:0];
                body_vel[i] = sat_add(body_vel[i], body_pos[i] > 0, dm);
            end
        end
        body_clock = sat_add(body_clock, 1'b0, {32'b0, h_reg});
        e.pos = body_pos;
        e.vel = body_vel;
        e.radius = r[47:0];
        return e;
    endfunction

    task automatic report(string what, logic [47:0] exp_v, logic [47:0] act_v);
        if (fail_count < 10)
            $display("mismatch on %s at %0t: expected %h, got %h", what, $time, exp_v, act_v);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        orbit_state_t e;
        if (!aresetn) begin
            h_reg <= oes_pkg::STEP_RESET;
            gm_reg <= oes_pkg::GRAV_RESET;
            for (int i = 0; i < 3; i++) begin
                body_pos[i] = '0;
                body_vel[i] = '0;
            end
            body_clock = '0;
            fail_count = 0;
            steps_seen = 0;
            singular_seen = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == oes_pkg::REG_TIME_STEP)
                    h_reg <= cfg_data[oes_pkg::STEP_W-1:0];
                else if (cfg_index == oes_pkg::REG_GRAV_MASS)
                    gm_reg <= cfg_data[oes_pkg::GRAV_W-1:0];
            end
            if (s_valid && s_ready) begin
                if (s_command == oes_pkg::CMD_LOAD) begin
                    body_pos[0] = s_load_x;
                    body_pos[1] = s_load_y;
                    body_pos[2] = s_load_z;
                    body_vel[0] = s_load_vx;
                    body_vel[1] = s_load_vy;
                    body_vel[2] = s_load_vz;
                    body_clock = s_start_time;
                end else begin
                    awaited.push_back(advance_body());
                end
            end
            if (m_valid && m_ready) begin
                if (awaited.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result at %0t", $time);
                    fail_count++;
                end else begin
                    e = awaited.pop_front();
                    steps_seen++;
                    if (m_singular) singular_seen++;
                    if (m_sim_time !== e.sim_time) report("sim_time", e.sim_time, m_sim_time);
                    if (m_pos_x !== e.pos[0]) report("pos_x", e.pos[0], m_pos_x);
                    if (m_pos_y !== e.pos[1]) report("pos_y", e.pos[1], m_pos_y);
                    if (m_pos_z !== e.pos[2]) report("pos_z", e.pos[2], m_pos_z);
                    if (m_vel_x !== e.vel[0]) report("vel_x", e.vel[0], m_vel_x);
                    if (m_vel_y !== e.vel[1]) report("vel_y", e.vel[1], m_vel_y);
                    if (m_vel_z !== e.vel[2]) report("vel_z", e.vel[2], m_vel_z);
                    if (m_radius !== e.radius) report("radius", e.radius, m_radius);
                    if (m_singular !== e.singular)
                        report("singular", {47'b0, e.singular}, {47'b0, m_singular});
                end
            end
        end
    end
endmodule

@@ verif/tb_top.sv @@
// Top of the orbit stepper testbench: clock, reset, request stimulus, stalls and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Indexes beyond the register list; writes to them must be ignored.
    localparam logic [oes_pkg::CFG_IDX_W-1:0] REG_SPARE_LOW  = 8'd2;
    localparam logic [oes_pkg::CFG_IDX_W-1:0] REG_SPARE_HIGH = 8'hFF;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_valid, cfg_ready;
    logic [oes_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [oes_pkg::CFG_DAT_W-1:0] cfg_data;
    logic                          s_valid, s_ready, s_command;
    logic signed [47:0]            s_load_x, s_load_y, s_load_z;
    logic signed [47:0]            s_load_vx, s_load_vy, s_load_vz, s_start_time;
    logic                          m_valid, m_ready;
    logic signed [47:0]            m_sim_time, m_pos_x, m_pos_y, m_pos_z;
    logic signed [47:0]            m_vel_x, m_vel_y, m_vel_z;
    logic [47:0]                   m_radius;
    logic                          m_singular;
    int                            fail_count, pending, steps_seen, singular_seen;
    bit                            calm;
    bit                            hold_req;
    int                            cfg_writes;

    orbit_euler_step uut (.*);

    oes_checker chk (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [47:0] rnd48();
        return 48'({$urandom, $urandom});
    endfunction

    // A random coordinate of zero to span + 1 AU with either sign, or a velocity of similar size.
    function automatic logic signed [47:0] near_unit(int span);
        logic signed [47:0] v;
        v = $signed({16'b0, $urandom}) + $signed(48'($urandom_range(0, span)) << 32);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
    endtask

    task automatic push(logic cmd, logic signed [47:0] x, y, z, vx, vy, vz, t0);
        sender_gap();
        s_valid <= 1'b1;
        s_command <= cmd;
        s_load_x <= x;
        s_load_y <= y;
        s_load_z <= z;
        s_load_vx <= vx;
        s_load_vy <= vy;
        s_load_vz <= vz;
        s_start_time <= t0;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic step_once();
        push(oes_pkg::CMD_STEP, rnd48(), rnd48(), rnd48(), rnd48(), rnd48(), rnd48(),
             rnd48());
    endtask

    // Registers change only once the block has drained every request.
    task automatic write_reg(logic [oes_pkg::CFG_IDX_W-1:0] idx,
                             logic [oes_pkg::CFG_DAT_W-1:0] data);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    initial begin
        m_ready <= 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (6000) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    initial begin
        logic signed [47:0] wmax, wmin;
        int                 items;
        int                 nsteps;
        wmax = 48'sh7FFF_FFFF_FFFF;
        wmin = 48'sh8000_0000_0000;
        items = 0;
        cfg_writes = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_command = oes_pkg::CMD_LOAD;
        {s_load_x, s_load_y, s_load_z} = '0;
        {s_load_vx, s_load_vy, s_load_vz, s_start_time} = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: a step from the reset state sits at the origin, so it is singular.
        step_once();
        push(oes_pkg::CMD_LOAD, 48'sd1 <<< 32, 0, 0, 0, 48'sd27 <<< 29, 0, 0);
        repeat (3) step_once();
        push(oes_pkg::CMD_LOAD, wmax, wmax, wmax, wmax, wmax, wmax, wmax);
        repeat (2) step_once();
        push(oes_pkg::CMD_LOAD, wmin, wmin, wmin, wmin, wmin, wmin, wmin);
        repeat (2) step_once();
        push(oes_pkg::CMD_LOAD, 0, 0, 0, 0, 0, 0, wmax - 5);
        step_once();
        push(oes_pkg::CMD_LOAD, 1, -1, 0, -1, 1, 0, 0);
        repeat (2) step_once();
        write_reg(oes_pkg::REG_TIME_STEP, 48'hFFFF_FFFF_FFFF);
        write_reg(oes_pkg::REG_GRAV_MASS, '1);
        push(oes_pkg::CMD_LOAD, 48'sd1 <<< 32, -(48'sd1 <<< 31), 48'sd3, 48'sd5, -48'sd5, 0,
             wmax - 1);
        repeat (2) step_once();
        write_reg(oes_pkg::REG_TIME_STEP, 48'd1);
        write_reg(oes_pkg::REG_GRAV_MASS, 48'd0);
        push(oes_pkg::CMD_LOAD, 48'sd2 <<< 32, 48'sd1, -48'sd1, 48'sd9, 0, 0, wmin);
        repeat (2) step_once();
        write_reg(REG_SPARE_LOW, rnd48());
        write_reg(REG_SPARE_HIGH, rnd48());
        items = 22;

        // Random phases under varying register settings.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: write_reg(oes_pkg::REG_TIME_STEP,
                             {16'hDEAD, 32'($urandom_range(1, 20000000))});
                1: write_reg(oes_pkg::REG_TIME_STEP,
                             ($urandom_range(0, 1) ? 48'd1 : 48'hFFFF_FFFF));
                2: write_reg(oes_pkg::REG_TIME_STEP, rnd48() | 48'd1);
                default: write_reg(oes_pkg::REG_TIME_STEP, 48'(oes_pkg::STEP_RESET));
            endcase
            case (ph % 3)
                0: write_reg(oes_pkg::REG_GRAV_MASS, oes_pkg::GRAV_RESET);
                1: write_reg(oes_pkg::REG_GRAV_MASS, rnd48());
                default: write_reg(oes_pkg::REG_GRAV_MASS,
                                   ($urandom_range(0, 1) ? '1 : 48'd0));
            endcase
            if (ph == 7) calm = 1'b1;
            if (ph == 3) hold_req = 1'b1;
            while (items < 22 + (ph + 1) * 97) begin
                if ($urandom_range(0, 5) == 0) begin
                    // Noise: any bit pattern in every field.
                    push(oes_pkg::CMD_LOAD, rnd48(), rnd48(), rnd48(), rnd48(), rnd48(),
                         rnd48(), rnd48());
                    nsteps = $urandom_range(1, 4);
                end else begin
                    push(oes_pkg::CMD_LOAD, near_unit(3), near_unit(3), near_unit(1),
                         near_unit(7), near_unit(7), near_unit(2), near_unit(100));
                    nsteps = $urandom_range(5, 20);
                end
                items += 1 + nsteps;
                repeat (nsteps) step_once();
            end
        end
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("run covered %0d requests, %0d step results (%0d singular), %0d register writes",
                 items, steps_seen, singular_seen, cfg_writes);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(8ns * 8000000);
        $display("timeout with %0d results outstanding", pending);
        $display("FAIL");
        $finish;
    end
endmodule
